/* rtl/core/iirdf_pkg.sv */
package iirdf_pkg;

  // fixed field widths and number formats
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 32;
  localparam int COEF_FRAC     = COEF_W - 8;
  localparam int OUT_W         = 32;
  localparam int ORDER_W       = 5;
  localparam int INDEX_W       = 5;
  localparam int MAX_POLES_DEF = 20;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // coefficient banks
  localparam logic BANK_FF = 1'b0;
  localparam logic BANK_FB = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // which operand a product term takes
  typedef enum logic [1:0] {
    TERM_X,
    TERM_XH,
    TERM_YH
  } term_t;

endpackage

/* rtl/core/iirdf_ram.sv */
module iirdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/iir_direct_form_filter.sv */
// Direct-form-I IIR filter, one shared multiply-accumulate unit.
// Input channel (in_valid/in_ready): kind selects a sample transaction
// (sample_in, Q1.15) or a coefficient load (coef_bank, coef_index,
// coef_value in Q8.24). A load into an index above MAX_POLES is dropped.
// Output channel (out_valid/out_ready): one filtered_out per sample,
// 15 fraction bits, rounded half up and saturated to 32 bits.
// Config channel (cfg_valid/cfg_ready): order_in_use, the number of poles P,
// clamped to MAX_POLES; write it only while the filter is idle.
// Sequence: a coefficient load leaves the filter idle and ready for the next
// item. A sample issues 2*P+1 products, one per cycle through the coefficient
// and history memories, then drains a three-stage read/multiply/accumulate
// pipe; the rounded result goes to yreg and on to the output register, and
// only after that hand-off is the next item taken.
// The result sits in an output register; a stalled receiver keeps a finished
// sample in its final cycle until that register is free, and no new item is
// taken meanwhile.
// Reset: order_in_use returns to 4, coefficients read as zero through valid
// bits and the histories through a fill count, so no clearing pass is needed.
module iir_direct_form_filter #(
  parameter int MaxPoles = iirdf_pkg::MAX_POLES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    kind,
  input  logic signed [iirdf_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                                    coef_bank,
  input  logic        [iirdf_pkg::INDEX_W-1:0]    coef_index,
  input  logic signed [iirdf_pkg::COEF_W-1:0]     coef_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [iirdf_pkg::OUT_W-1:0]      filtered_out,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [iirdf_pkg::ORDER_W-1:0]    order_in_use
);

  import iirdf_pkg::*;

  localparam int TW     = $clog2(MaxPoles + 1);
  localparam int CDEPTH = 2 ** (TW + 1);
  localparam int HAW    = (MaxPoles > 1) ? $clog2(MaxPoles) : 1;
  localparam int HW     = SAMPLE_W + OUT_W;
  localparam int PROD_W = COEF_W + OUT_W;
  localparam int ACC_W  = PROD_W + $clog2(2 * MaxPoles + 1) + 1;

  state_t state, state_next;

  logic [ORDER_W-1:0]       order_cfg;
  logic [CDEPTH-1:0]        cvalid;
  logic [HAW-1:0]           wp;
  logic [HAW-1:0]           ptr;
  logic [TW-1:0]            fill;
  logic [TW-1:0]            tap;
  logic                     fb;
  logic [TW-1:0]            p_lat;
  logic [TW-1:0]            p_eff;
  logic signed [SAMPLE_W-1:0] x_cur;

  logic                     s1_valid;
  term_t                    s1_type;
  logic                     s1_cval;
  logic                     s1_hval;
  logic                     p_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OUT_W-1:0]  yreg;

  logic                     in_fire;
  logic                     sample_fire;
  logic                     coef_fire;
  logic                     coef_in_range;
  logic                     out_free;
  logic                     out_load;
  logic                     last_term;
  logic                     drained;
  term_t                    issue_type;
  logic [TW:0]              c_raddr;
  logic [TW:0]              c_waddr;
  logic [COEF_W-1:0]        c_rdata;
  logic [HAW-1:0]           wp_prev;
  logic [HW-1:0]            h_rdata;

  logic signed [COEF_W-1:0] c_op;
  logic signed [OUT_W-1:0]  d_op;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]  rnd_shr;
  logic [ACC_W-OUT_W:0]     rnd_hi;
  logic signed [OUT_W-1:0]  y_round;

  // handshakes
  assign in_ready      = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = in_valid && in_ready;
  assign sample_fire   = in_fire && (kind == KIND_SAMPLE);
  assign coef_fire     = in_fire && (kind == KIND_COEF);
  assign coef_in_range = (int'(coef_index) <= MaxPoles);
  assign out_free      = !out_valid || out_ready;
  assign out_load      = (state == ST_OUT) && out_free;
  assign drained       = !s1_valid && !p_valid;

  // order clamp and pointer to the newest history entry
  assign p_eff   = (int'(order_cfg) > MaxPoles) ? TW'(MaxPoles) : TW'(order_cfg);
  assign wp_prev = (wp == '0) ? HAW'(MaxPoles - 1) : wp - 1'b1;

  // term sequence: a0*x, then per tap a[k]*x[n-k] and b[k]*y[n-k]
  always_comb begin
    if (tap == '0) begin
      issue_type = TERM_X;
      c_raddr    = {BANK_FF, tap};
      last_term  = (p_lat == '0);
    end else if (!fb) begin
      issue_type = TERM_XH;
      c_raddr    = {BANK_FF, tap};
      last_term  = 1'b0;
    end else begin
      issue_type = TERM_YH;
      c_raddr    = {BANK_FB, tap};
      last_term  = (tap == p_lat);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_fire) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (last_term) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // coefficient store: {bank, tap}
  assign c_waddr = {coef_bank, TW'(coef_index)};

  iirdf_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_fire && coef_in_range),
    .waddr (c_waddr),
    .wdata (coef_value),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // history store: circular, each entry holds {x, y} of one past sample
  iirdf_ram #(
    .WIDTH (HW),
    .DEPTH (MaxPoles)
  ) u_hist_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (wp),
    .wdata ({x_cur, yreg}),
    .raddr (ptr),
    .rdata (h_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_cfg <= ORDER_RESET;
      cvalid    <= '0;
      wp        <= '0;
      fill      <= '0;
      s1_valid  <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
      tap       <= '0;
      fb        <= 1'b0;
      p_lat     <= '0;
      ptr       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_cfg <= order_in_use;
      end
      if (coef_fire && coef_in_range) begin
        cvalid[c_waddr] <= 1'b1;
      end

      // sample start
      if (sample_fire) begin
        tap   <= '0;
        fb    <= 1'b0;
        p_lat <= p_eff;
        ptr   <= wp_prev;
      end

      // term issue
      s1_valid <= (state == ST_ISSUE);
      if (state == ST_ISSUE) begin
        if (tap == '0) begin
          tap <= TW'(1);
        end else if (!fb) begin
          fb <= 1'b1;
        end else begin
          fb  <= 1'b0;
          tap <= tap + 1'b1;
          ptr <= (ptr == '0) ? HAW'(MaxPoles - 1) : ptr - 1'b1;
        end
      end
      p_valid <= s1_valid;

      // result hand-off and history advance
      if (out_load) begin
        out_valid <= 1'b1;
        wp        <= (wp == HAW'(MaxPoles - 1)) ? '0 : wp + 1'b1;
        if (fill != TW'(MaxPoles)) begin
          fill <= fill + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // operand select behind the memory read
  always_comb begin
    c_op = s1_cval ? signed'(c_rdata) : '0;
    case (s1_type)
      TERM_X:  d_op = {{(OUT_W - SAMPLE_W){x_cur[SAMPLE_W-1]}}, x_cur};
      TERM_XH: d_op = s1_hval ?
                      {{(OUT_W - SAMPLE_W){h_rdata[HW-1]}}, h_rdata[HW-1:OUT_W]} : '0;
      TERM_YH: d_op = s1_hval ? signed'(h_rdata[OUT_W-1:0]) : '0;
      default: d_op = '0;
    endcase
  end

  // round half up, drop COEF_FRAC bits, saturate
  always_comb begin
    rnd_sum = acc + (ACC_W'(1) <<< (COEF_FRAC - 1));
    rnd_shr = rnd_sum >>> COEF_FRAC;
    rnd_hi  = rnd_shr[ACC_W-1:OUT_W-1];
    if ((&rnd_hi) || !(|rnd_hi)) begin
      y_round = rnd_shr[OUT_W-1:0];
    end else if (rnd_shr[ACC_W-1]) begin
      y_round = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      y_round = {1'b0, {(OUT_W - 1){1'b1}}};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      x_cur <= sample_in;
    end
    if (state == ST_ISSUE) begin
      s1_type <= issue_type;
      s1_cval <= cvalid[c_raddr];
      s1_hval <= (tap <= fill);
    end
    prod <= c_op * d_op;
    if (sample_fire) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    if ((state == ST_DRAIN) && drained) begin
      yreg <= y_round;
    end
    if (out_load) begin
      filtered_out <= yreg;
    end
  end

endmodule

/* rtl/core/iirdf_checker.sv */
module iirdf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  kind,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [iirdf_pkg::OUT_W-1:0]    filtered_out
);

  import iirdf_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_out))
    else $error("stalled result changed");

  // a coefficient load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_COEF) && !out_valid |=> !out_valid)
    else $error("coefficient load produced a result");

  // the filter is busy after a sample transaction
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_SAMPLE) |=> !in_ready)
    else $error("input taken while a sample is in flight");

endmodule

bind iir_direct_form_filter iirdf_checker u_iirdf_checker (.*);

/* bench/iir_output_checker.sv */
module iir_output_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  kind,
  input  logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                  coef_bank,
  input  logic        [iirdf_pkg::INDEX_W-1:0]  coef_index,
  input  logic signed [iirdf_pkg::COEF_W-1:0]   coef_value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [iirdf_pkg::OUT_W-1:0]    filtered_out,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic        [iirdf_pkg::ORDER_W-1:0]  order_in_use,
  output int                                    fail_count,
  output int                                    owed_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import iirdf_pkg::*;

  localparam int Poles = MAX_POLES_DEF;
  localparam int AccW = 80;
  localparam logic signed [AccW-1:0] OutMax = {{(AccW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [AccW-1:0] OutMin = ~OutMax;
  localparam logic signed [AccW-1:0] RoundHalf = {{(AccW-1){1'b0}}, 1'b1} << (COEF_FRAC-1);

  // filter state as the block should hold it
  logic        [ORDER_W-1:0]  order_now;
  logic signed [SAMPLE_W-1:0] x_past  [Poles];
  logic signed [OUT_W-1:0]    y_past  [Poles];
  logic signed [COEF_W-1:0]   ff_taps [Poles+1];
  logic signed [COEF_W-1:0]   fb_taps [Poles+1];
  logic signed [OUT_W-1:0]    outputs_due [$];

  // exact sum of products, rounded half up to 15 fraction bits and clipped
  function automatic logic signed [OUT_W-1:0] filter_output(
      input logic signed [SAMPLE_W-1:0] x);
    logic signed [AccW-1:0] acc;
    int taps;
    taps = (order_now > Poles) ? Poles : int'(order_now);
    acc = ff_taps[0] * x;
    for (int k = 1; k <= taps; k++) begin
      acc = acc + ff_taps[k] * x_past[k-1];
      acc = acc + fb_taps[k] * y_past[k-1];
    end
    acc = (acc + RoundHalf) >>> COEF_FRAC;
    if (acc > OutMax) begin
      acc = OutMax;
    end else if (acc < OutMin) begin
      acc = OutMin;
    end
    return acc[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    logic signed [OUT_W-1:0] due;
    if (rst) begin
      order_now = ORDER_RESET;
      foreach (x_past[i]) begin
        x_past[i] = '0;
        y_past[i] = '0;
      end
      foreach (ff_taps[i]) begin
        ff_taps[i] = '0;
        fb_taps[i] = '0;
      end
      outputs_due.delete();
      fail_count = 0;
      owed_count = 0;
    end else begin
      // output transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (outputs_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: filtered_out %0d with no sample outstanding, expected none",
                   $time, filtered_out);
        end else begin
          due = outputs_due.pop_front();
          if (filtered_out !== due) begin
            fail_count++;
            $display("%0t ns: filtered_out mismatch, expected %0d, actual %0d",
                     $time, due, filtered_out);
          end
        end
      end

      // order register write
      if (cfg_valid && cfg_ready) begin
        order_now = order_in_use;
      end

      // input transaction: coefficient load or one filtered sample
      if (in_valid && in_ready) begin
        if (kind == KIND_COEF) begin
          if (coef_index <= Poles) begin
            if (coef_bank == BANK_FB) begin
              fb_taps[coef_index] = coef_value;
            end else begin
              ff_taps[coef_index] = coef_value;
            end
          end
        end else begin
          due = filter_output(sample_in);
          // both histories shift in full, whatever the order
          for (int k = Poles - 1; k > 0; k--) begin
            x_past[k] = x_past[k-1];
            y_past[k] = y_past[k-1];
          end
          x_past[0] = sample_in;
          y_past[0] = due;
          outputs_due = {outputs_due, due};
        end
      end
      owed_count = outputs_due.size();
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import iirdf_pkg::*;

  localparam int Poles = MAX_POLES_DEF;
  localparam int Settle = 2 * Poles + 10;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 2000;
  localparam int Phases = 24;
  localparam int PhaseItems = 44;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       coef_bank;
  logic        [INDEX_W-1:0]  coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [OUT_W-1:0]    filtered_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic        [ORDER_W-1:0]  order_in_use;

  int   mismatches;
  int   outputs_owed;
  int   quiet_cycles;
  int   burst_left;
  logic gaps_on;
  logic hold_armed;

  iir_direct_form_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .sample_in    (sample_in),
    .coef_bank    (coef_bank),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .filtered_out (filtered_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .order_in_use (order_in_use)
  );

  iir_output_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .sample_in    (sample_in),
    .coef_bank    (coef_bank),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .filtered_out (filtered_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .order_in_use (order_in_use),
    .fail_count   (mismatches),
    .owed_count   (outputs_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: changing stall styles, plus one long hold-off when armed
  initial begin : receiver
    int style;
    int style_left;
    int tick;
    logic hold_done;
    out_ready = 1'b0;
    style = 0;
    style_left = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(40, 400);
      end
      style_left--;
      tick++;
      case (style)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        2: out_ready = ($urandom_range(0, 5) == 0);
        default: out_ready = (tick % 7) > 2;
      endcase
    end
  end

  // Q8.24 coefficient within +-0.25
  function automatic logic signed [COEF_W-1:0] small_coef();
    return int'($urandom_range(0, 1 << 23)) - (1 << 22);
  endfunction

  // mostly full-scale samples, some near zero
  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    if ($urandom_range(0, 3) == 0) begin
      return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
    end
    return SAMPLE_W'($urandom);
  endfunction

  // one input transaction; valid stays up within a burst, drops for a gap after it
  task automatic push_item(input logic k, input logic signed [SAMPLE_W-1:0] s,
                           input logic b, input logic [INDEX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] v);
    kind = k;
    sample_in = s;
    coef_bank = b;
    coef_index = idx;
    coef_value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic feed_sample(input logic signed [SAMPLE_W-1:0] s);
    push_item(KIND_SAMPLE, s, 1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, 31)),
              COEF_W'($urandom));
  endtask

  task automatic load_coef(input logic b, input logic [INDEX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] v);
    push_item(KIND_COEF, any_sample(), b, idx, v);
  endtask

  // write the order only once the filter has drained
  task automatic set_order(input logic [ORDER_W-1:0] p);
    in_valid = 1'b0;
    while (outputs_owed != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
    order_in_use = p;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // moderate feed-forward taps and small feedback taps, mostly stable
  task automatic load_coef_set(input int taps);
    int span;
    span = (1 << 24) / (2 * taps + 2);
    for (int k = 0; k <= taps; k++) begin
      load_coef(BANK_FF, INDEX_W'(k), small_coef());
      if (k > 0) begin
        load_coef(BANK_FB, INDEX_W'(k), int'($urandom_range(0, 2 * span)) - span);
      end
    end
  endtask

  initial begin : stimulus
    int ord;
    int taps;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_SAMPLE;
    sample_in = '0;
    coef_bank = BANK_FF;
    coef_index = '0;
    coef_value = '0;
    cfg_valid = 1'b0;
    order_in_use = ORDER_RESET;
    gaps_on = 1'b0;
    burst_left = 0;
    hold_armed = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // all coefficients read as zero after reset
    feed_sample(16'sh7FFF);
    // a0 = 0.5: halves round up, so -0.5 goes to zero
    load_coef(BANK_FF, INDEX_W'(0), 32'sh0080_0000);
    feed_sample(16'sd1);
    feed_sample(-16'sd1);
    feed_sample(16'sd3);
    // loads beyond the last tap are dropped
    load_coef(BANK_FF, INDEX_W'(31), -32'sd1);
    load_coef(BANK_FB, INDEX_W'(21), 32'sh1234_5678);
    // extreme coefficients and samples
    load_coef(BANK_FF, INDEX_W'(0), 32'sh7FFF_FFFF);
    feed_sample(16'sh7FFF);
    feed_sample(16'sh8000);
    load_coef(BANK_FF, INDEX_W'(4), 32'sh8000_0000);
    // feedback tap zero is writable but never used
    load_coef(BANK_FB, INDEX_W'(0), 32'sh7FFF_FFFF);
    // feedback gain near +128 runs into positive clipping
    load_coef(BANK_FB, INDEX_W'(1), 32'sh7FFF_FFFF);
    feed_sample(16'sh7FFF);
    feed_sample(16'sh7FFF);
    // gain near -128 swings to negative clipping and back
    load_coef(BANK_FB, INDEX_W'(1), 32'sh8000_0000);
    feed_sample('0);
    feed_sample('0);
    // order zero: only the current sample counts
    set_order('0);
    feed_sample(16'sd1000);
    feed_sample(-16'sd1);
    // order above the maximum is clamped
    set_order(5'd31);
    load_coef(BANK_FF, INDEX_W'(Poles), 32'sh0100_0000);
    load_coef(BANK_FB, INDEX_W'(Poles), 32'shFF00_0000);
    feed_sample(16'sh4000);

    // random phases, each with its own order and traffic shape
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: ord = 1;
        1: ord = Poles;
        2: ord = 3;
        3: ord = 0;
        4: ord = 31;
        default: ord = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6)
                                                    : $urandom_range(0, 31);
      endcase
      set_order(ORDER_W'(ord));
      taps = (ord > Poles) ? Poles : ord;
      gaps_on = (ph != 2) && ($urandom_range(0, 3) != 0);
      // long receiver hold-off while samples keep coming
      if (ph == 2) begin
        hold_armed = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        load_coef_set(taps);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(0, 9))
          0: load_coef(1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, 31)),
                       COEF_W'($urandom));
          1: load_coef(1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, Poles)),
                       small_coef());
          default: feed_sample(any_sample());
        endcase
      end
    end

    // drain and verdict
    in_valid = 1'b0;
    while (outputs_owed != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
